### rtl/abel_variation_bound_scan_assert.svh
// assertion macros for the variation bound scan
`ifndef ABEL_VARIATION_BOUND_SCAN_ASSERT_SVH
`define ABEL_VARIATION_BOUND_SCAN_ASSERT_SVH
`ifndef SYNTHESIS
`define AVBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("avbs check failed");
`define AVBS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("avbs check failed");
`else
`define AVBS_ASSERT(lbl, prop)
`define AVBS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/avbs_pkg.sv
package avbs_pkg;

  localparam int unsigned MAG_BITS = 48;
  localparam int unsigned ROOT_BITS = 60;
  localparam int unsigned PROD_BITS = 109;

  localparam logic [6:0] DIV_LAST = 7'd127;
  localparam logic [6:0] SQRT_LAST = 7'd59;
  localparam logic [6:0] MUL_LAST = 7'd47;

  localparam logic [63:0] SCALE = 64'd1000000000000000000;
  localparam logic [127:0] SCALE_SQ = 128'd1000000000000000000000000000000000000;
  localparam logic [62:0] SAT63 = {63{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ROOT_INIT,
    ST_SQRT,
    ST_MUL_INIT,
    ST_MUL,
    ST_ACC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic root_init;
    logic sqrt_step;
    logic mul_init;
    logic mul_step;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic inc_nz;
    logic last;
  } status_t;

endpackage

### rtl/avbs_ctrl.sv
module avbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  avbs_pkg::status_t sts,
  output avbs_pkg::cmd_t    cmd
);
  import avbs_pkg::*;

  state_t state, state_next;
  logic [6:0] cnt, cnt_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_CHECK;
      ST_CHECK:     state_next = sts.inc_nz ? ST_DIV : ST_FINISH;
      ST_DIV:       if (cnt == DIV_LAST) state_next = ST_ROOT_INIT;
      ST_ROOT_INIT: state_next = ST_SQRT;
      ST_SQRT:      if (cnt == SQRT_LAST) state_next = ST_MUL_INIT;
      ST_MUL_INIT:  state_next = ST_MUL;
      ST_MUL:       if (cnt == MUL_LAST) state_next = ST_ACC;
      ST_ACC:       state_next = ST_FINISH;
      ST_FINISH: begin
        if (!sts.last || !out_valid || !out_stall) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
    cnt_next = (state_next != state) ? 7'd0 : cnt + 7'd1;
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE:      cmd.load = in_valid;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_ROOT_INIT: cmd.root_init = 1'b1;
      ST_SQRT:      cmd.sqrt_step = 1'b1;
      ST_MUL_INIT:  cmd.mul_init = 1'b1;
      ST_MUL:       cmd.mul_step = 1'b1;
      ST_ACC:       cmd.acc = 1'b1;
      ST_FINISH:    cmd.emit = sts.last && (!out_valid || !out_stall);
      default:      cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= 7'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/avbs_dp.sv
module avbs_dp #(
  parameter int unsigned INDEX_BITS = 40,
  parameter int unsigned DELTA_BITS = 19
) (
  input  logic                    clk,
  input  logic                    rst,
  input  avbs_pkg::cmd_t          cmd,
  output avbs_pkg::status_t       sts,
  input  logic [INDEX_BITS-1:0]   index,
  input  logic signed [DELTA_BITS:0] delta,
  input  logic                    last,
  output logic signed [47:0]      final_prefix,
  output logic [47:0]             final_error,
  output logic [62:0]             variation_total,
  output logic signed [63:0]      u_bound_high,
  output logic [63:0]             u_bound_low,
  output logic [63:0]             v_bound_high,
  output logic [63:0]             v_bound_low
);
  import avbs_pkg::*;

  // accumulated state
  logic signed [47:0] prefix_sum;
  logic [47:0] previous_error;
  logic [62:0] variation_sum;
  logic [127:0] u_accum, v_accum;

  // per item
  logic [INDEX_BITS-1:0] n;
  logic [MAG_BITS-1:0] mag;
  logic inc_pos, inc_nz, last_flag;

  // dividers
  logic [127:0] div_a, div_b, quo_a;
  logic [63:0] quo_b;
  logic [INDEX_BITS-1:0] rem_a, rem_b;
  logic [INDEX_BITS:0] try_a, try_b;
  logic ge_a, ge_b;

  // square root
  logic [119:0] rad;
  logic [61:0] sq_rem;
  logic [ROOT_BITS-1:0] root;
  logic [63:0] sq_try, sq_trial;
  logic sq_ge;
  logic [127:0] ceil_quo;

  // multipliers
  logic [PROD_BITS-1:0] prod_u, prod_v;
  logic [ROOT_BITS-1:0] mcand_u, mcand_v;
  logic [60:0] sum_u, sum_v;

  // load arithmetic
  logic signed [47:0] f_new;
  logic signed [48:0] one_minus, inc;
  logic [48:0] err_abs;
  logic [48:0] inc_abs;
  logic [63:0] var_sum;

  always_comb begin
    f_new = prefix_sum + 48'(delta);
    one_minus = 49'sd1 - 49'(f_new);
    err_abs = one_minus[48] ? 49'(-one_minus) : 49'(one_minus);
    inc = $signed({1'b0, err_abs[47:0]}) - $signed({1'b0, previous_error});
    inc_abs = inc[48] ? 49'(-inc) : 49'(inc);
    var_sum = {1'b0, variation_sum} + 64'(inc_abs[47:0]);

    try_a = {rem_a, div_a[127]};
    try_b = {rem_b, div_b[127]};
    ge_a = (try_a >= {1'b0, n});
    ge_b = (try_b >= {1'b0, n});

    ceil_quo = quo_a + 128'(rem_a != '0);

    sq_try = {sq_rem, rad[119:118]};
    sq_trial = {2'b00, root, 2'b01};
    sq_ge = (sq_try >= sq_trial);

    sum_u = {1'b0, prod_u[PROD_BITS-2:MAG_BITS]}
            + (prod_u[0] ? {1'b0, mcand_u} : 61'd0);
    sum_v = {1'b0, prod_v[PROD_BITS-2:MAG_BITS]}
            + (prod_v[0] ? {1'b0, mcand_v} : 61'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_sum <= '0;
      previous_error <= '0;
      variation_sum <= '0;
      u_accum <= '0;
      v_accum <= '0;
    end else begin
      if (cmd.load) begin
        prefix_sum <= f_new;
        previous_error <= err_abs[47:0];
        variation_sum <= var_sum[63] ? SAT63 : var_sum[62:0];
      end
      if (cmd.acc) begin
        u_accum <= inc_pos ? u_accum + 128'(prod_u) : u_accum - 128'(prod_u);
        v_accum <= v_accum + 128'(prod_v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= (index == '0) ? INDEX_BITS'(1) : index;
      mag <= inc_abs[47:0];
      inc_pos <= !inc[48] && (inc != '0);
      inc_nz <= (inc != '0);
      last_flag <= last;
      div_a <= SCALE_SQ;
      div_b <= {64'd0, SCALE};
      rem_a <= '0;
      rem_b <= '0;
    end
    if (cmd.div_step) begin
      div_a <= {div_a[126:0], 1'b0};
      div_b <= {div_b[126:0], 1'b0};
      rem_a <= ge_a ? INDEX_BITS'(try_a - {1'b0, n}) : try_a[INDEX_BITS-1:0];
      rem_b <= ge_b ? INDEX_BITS'(try_b - {1'b0, n}) : try_b[INDEX_BITS-1:0];
      quo_a <= {quo_a[126:0], ge_a};
      quo_b <= {quo_b[62:0], ge_b};
    end
    if (cmd.root_init) begin
      rad <= ceil_quo[119:0];
      sq_rem <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      rad <= {rad[117:0], 2'b00};
      sq_rem <= sq_ge ? 62'(sq_try - sq_trial) : sq_try[61:0];
      root <= {root[ROOT_BITS-2:0], sq_ge};
    end
    if (cmd.mul_init) begin
      prod_u <= PROD_BITS'(mag);
      prod_v <= PROD_BITS'(mag);
      mcand_u <= quo_b[ROOT_BITS-1:0] + ROOT_BITS'(inc_pos && (rem_b != '0));
      mcand_v <= root + ROOT_BITS'(sq_rem != '0);
    end
    if (cmd.mul_step) begin
      prod_u <= {1'b0, sum_u, prod_u[MAG_BITS-1:1]};
      prod_v <= {1'b0, sum_v, prod_v[MAG_BITS-1:1]};
    end
    if (cmd.emit) begin
      final_prefix <= prefix_sum;
      final_error <= previous_error;
      variation_total <= variation_sum;
      u_bound_high <= u_accum[127:64];
      u_bound_low <= u_accum[63:0];
      v_bound_high <= v_accum[127:64];
      v_bound_low <= v_accum[63:0];
    end
  end

  assign sts.inc_nz = inc_nz;
  assign sts.last = last_flag;

endmodule

### rtl/abel_variation_bound_scan.sv
// abel variation bound scan
// input channel: in_valid / in_stall carry one beat per index (index, delta, last),
// indices in order from 1; output channel: out_valid / out_stall carry one result beat
// after each beat with last set: final prefix, final error, variation, U and V halves
// an item whose error increment is zero goes from the check straight to finish;
// any other item runs in turn bit-serial long division of both quotients
// (10^36 / n and 10^18 / n side by side), a digit-by-digit square root, a
// shift-add multiply for both weights, then the 128-bit accumulate
// the next item is taken while a result beat still waits in the output register;
// only a further last item holds in its final cycle until the waiting beat is taken
// reset (rst, synchronous) clears the prefix sum, error, variation and both bounds,
// and drops out_valid; state is kept after a last item until the next reset
// a stalled result beat stays unchanged on the output ports
module abel_variation_bound_scan #(
  parameter int unsigned INDEX_BITS = 40,
  parameter int unsigned DELTA_BITS = 19
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [INDEX_BITS-1:0]      index,
  input  logic signed [DELTA_BITS:0] delta,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [47:0]         final_prefix,
  output logic [47:0]                final_error,
  output logic [62:0]                variation_total,
  output logic signed [63:0]         u_bound_high,
  output logic [63:0]                u_bound_low,
  output logic [63:0]                v_bound_high,
  output logic [63:0]                v_bound_low
);
  import avbs_pkg::*;

  `include "abel_variation_bound_scan_assert.svh"

  cmd_t cmd;
  status_t sts;

  // sequencer: steps the shared units through one item
  avbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic units, running state and result register
  avbs_dp #(
    .INDEX_BITS (INDEX_BITS),
    .DELTA_BITS (DELTA_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .index           (index),
    .delta           (delta),
    .last            (last),
    .final_prefix    (final_prefix),
    .final_error     (final_error),
    .variation_total (variation_total),
    .u_bound_high    (u_bound_high),
    .u_bound_low     (u_bound_low),
    .v_bound_high    (v_bound_high),
    .v_bound_low     (v_bound_low)
  );

  // a new result never overwrites a beat the receiver has not taken
  `AVBS_ASSERT(a_no_overwrite, cmd.emit |-> !(out_valid && out_stall))
  // result beat appears only right after an emit
  `AVBS_ASSERT(a_valid_from_emit, $rose(out_valid) |-> $past(cmd.emit))
  // at most one datapath operation per cycle
  `AVBS_ASSERT_ALWAYS(a_one_op,
    $onehot0({cmd.load, cmd.div_step, cmd.root_init, cmd.sqrt_step, cmd.mul_init,
              cmd.mul_step, cmd.acc, cmd.emit}))

endmodule
